// ===== hdl/sdd_pkg.sv =====
package sdd_pkg;

    localparam int DECK_SIZE      = 52;
    localparam int CODE_W         = 6;
    localparam int RANKS_PER_SUIT = 13;
    localparam int SUIT_COUNT     = 4;

    // request codes
    localparam logic [1:0] REQ_BUILD   = 2'd0;
    localparam logic [1:0] REQ_SHUFFLE = 2'd1;
    localparam logic [1:0] REQ_DEAL    = 2'd2;

    typedef enum logic [1:0] {
        RD_POS,
        RD_J,
        RD_DEAL
    } rd_sel_t;

    typedef enum logic {
        WR_POS,
        WR_J
    } wr_sel_t;

    typedef struct packed {
        logic    load;
        logic    build;
        logic    div_step;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_en;
        wr_sel_t wr_sel;
        logic    cap_a;
        logic    swap_end;
        logic    refuse;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic k_zero;
        logic k_over;
        logic deal_end;
    } stat_t;

    function automatic logic [1:0] code_suit(input logic [CODE_W-1:0] code);
        logic [1:0] s;
        if (code >= CODE_W'(3 * RANKS_PER_SUIT))
            s = 2'd3;
        else if (code >= CODE_W'(2 * RANKS_PER_SUIT))
            s = 2'd2;
        else if (code >= CODE_W'(RANKS_PER_SUIT))
            s = 2'd1;
        else
            s = 2'd0;
        return s;
    endfunction

    function automatic logic [3:0] code_rank(input logic [CODE_W-1:0] code);
        logic [1:0]        s;
        logic [CODE_W-1:0] base;
        logic [CODE_W-1:0] r;
        s    = code_suit(code);
        base = CODE_W'(RANKS_PER_SUIT) * CODE_W'(s);
        r    = code - base + CODE_W'(1);
        return r[3:0];
    endfunction

endpackage

// ===== hdl/sdd_ram.sv =====
module sdd_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 52
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/sdd_ctrl.sv =====
module sdd_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [1:0]    req_type,
    input  sdd_pkg::stat_t stat,
    output sdd_pkg::cmd_t  cmd,
    output logic          busy
);

    import sdd_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_RD_POS,
        ST_RD_J,
        ST_WR_POS,
        ST_WR_J,
        ST_DEAL_CHK,
        ST_DEAL
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        cmd.rd_sel = RD_POS;
        cmd.wr_sel = WR_POS;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    case (req_type)
                        REQ_BUILD:   cmd.build  = 1'b1;
                        REQ_SHUFFLE: state_next = ST_DIV;
                        REQ_DEAL:    state_next = ST_DEAL_CHK;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done)
                    state_next = ST_RD_POS;
            end
            ST_RD_POS:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_POS;
                state_next = ST_RD_J;
            end
            ST_RD_J:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_J;
                cmd.cap_a  = 1'b1;
                state_next = ST_WR_POS;
            end
            ST_WR_POS:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_POS;
                state_next = ST_WR_J;
            end
            ST_WR_J:
            begin
                cmd.wr_en    = 1'b1;
                cmd.wr_sel   = WR_J;
                cmd.swap_end = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_DEAL_CHK:
            begin
                if (stat.k_zero)
                    state_next = ST_IDLE;
                else if (stat.k_over)
                begin
                    cmd.refuse = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                    state_next = ST_DEAL;
            end
            ST_DEAL:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_DEAL;
                if (stat.deal_end)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// ===== hdl/sdd_datapath.sv =====
module sdd_datapath #(
    parameter int RW = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [15:0]   rand_value,
    input  logic [5:0]    deal_count,
    input  sdd_pkg::cmd_t  cmd,
    output sdd_pkg::stat_t stat,
    output logic [1:0]    suit,
    output logic [3:0]    rank,
    output logic          last,
    output logic          refused,
    output logic          strobe
);

    import sdd_pkg::*;

    localparam int CNT_W = $clog2(RW);

    // divider: remainder of rand mod (pos + 1), one quotient bit per cycle
    logic [RW-1:0]     dvd_reg;
    logic [CODE_W-1:0] rem_reg;
    logic [CODE_W-1:0] rem_next;
    logic [CODE_W-1:0] dvs_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CODE_W:0]   rem_sh;

    logic [CODE_W-1:0] pos_reg;
    logic [CODE_W-1:0] dealt_reg;
    logic [CODE_W-1:0] k_reg;
    logic [CODE_W-1:0] n_reg;
    logic [CODE_W-1:0] a_reg;

    // entry valid bits; an unwritten entry holds its own index
    logic [DECK_SIZE-1:0] vld_reg;
    logic                 q_vld_reg;
    logic [CODE_W-1:0]    q_addr_reg;
    logic [CODE_W-1:0]    ram_q;
    logic [CODE_W-1:0]    entry;

    logic pend_vld_reg;
    logic pend_last_reg;

    logic [CODE_W-1:0] rd_addr;
    logic [CODE_W-1:0] wr_addr;
    logic [CODE_W-1:0] wr_data;
    logic              deal_rd;
    logic              deal_end;
    logic [CODE_W:0]   need;

    logic [1:0] suit_reg;
    logic [3:0] rank_reg;
    logic       last_reg;
    logic       refused_reg;
    logic       strobe_reg;

    assign rem_sh   = {rem_reg, dvd_reg[RW-1]};
    assign rem_next = (rem_sh >= {1'b0, dvs_reg}) ? CODE_W'(rem_sh - {1'b0, dvs_reg})
                                                  : rem_sh[CODE_W-1:0];

    assign entry = q_vld_reg ? ram_q : q_addr_reg;

    always_comb
    begin
        case (cmd.rd_sel)
            RD_POS:  rd_addr = pos_reg;
            RD_J:    rd_addr = rem_reg;
            RD_DEAL: rd_addr = dealt_reg + n_reg;
            default: rd_addr = pos_reg;
        endcase
    end

    assign wr_addr = (cmd.wr_sel == WR_J) ? rem_reg : pos_reg;
    assign wr_data = (cmd.wr_sel == WR_J) ? a_reg : entry;

    assign deal_rd  = cmd.rd_en && (cmd.rd_sel == RD_DEAL);
    assign deal_end = (n_reg == k_reg - CODE_W'(1));
    assign need     = {1'b0, k_reg} + {1'b0, dealt_reg};

    assign stat.div_done = (cnt_reg == CNT_W'(RW - 1));
    assign stat.k_zero   = (k_reg == '0);
    assign stat.k_over   = (need > (CODE_W + 1)'(DECK_SIZE));
    assign stat.deal_end = deal_end;

    sdd_ram #(
        .WIDTH (CODE_W),
        .DEPTH (DECK_SIZE)
    ) u_deck (
        .clk   (clk),
        .we    (cmd.wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (cmd.rd_en),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            dvd_reg <= rand_value[RW-1:0];
            rem_reg <= '0;
            dvs_reg <= pos_reg + CODE_W'(1);
            cnt_reg <= '0;
            k_reg   <= deal_count;
            n_reg   <= '0;
        end
        else
        begin
            if (cmd.div_step)
            begin
                dvd_reg <= {dvd_reg[RW-2:0], 1'b0};
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (deal_rd)
                n_reg <= n_reg + CODE_W'(1);
        end
        if (cmd.rd_en)
            q_addr_reg <= rd_addr;
        if (cmd.cap_a)
            a_reg <= entry;
        if (pend_vld_reg)
        begin
            suit_reg <= code_suit(entry);
            rank_reg <= code_rank(entry);
            last_reg <= pend_last_reg;
        end
        else if (cmd.refuse)
        begin
            suit_reg <= '0;
            rank_reg <= '0;
            last_reg <= 1'b1;
        end
        refused_reg <= cmd.refuse;
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= CODE_W'(DECK_SIZE - 1);
            dealt_reg     <= '0;
            vld_reg       <= '0;
            q_vld_reg     <= 1'b0;
            pend_vld_reg  <= 1'b0;
            pend_last_reg <= 1'b0;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.build)
            begin
                vld_reg   <= '0;
                dealt_reg <= '0;
            end
            else
            begin
                if (cmd.wr_en)
                    vld_reg[wr_addr] <= 1'b1;
                if (cmd.swap_end)
                begin
                    dealt_reg <= '0;
                    pos_reg   <= (pos_reg == '0) ? CODE_W'(DECK_SIZE - 1)
                                                 : pos_reg - CODE_W'(1);
                end
                else if (deal_rd && deal_end)
                    dealt_reg <= dealt_reg + k_reg;
            end
            if (cmd.rd_en)
                q_vld_reg <= vld_reg[rd_addr];
            pend_vld_reg  <= deal_rd;
            pend_last_reg <= deal_rd && deal_end;
            strobe_reg    <= pend_vld_reg || cmd.refuse;
        end
    end

    assign suit    = suit_reg;
    assign rank    = rank_reg;
    assign last    = last_reg;
    assign refused = refused_reg;
    assign strobe  = strobe_reg;

endmodule

// ===== hdl/shuffled_deck_dealer.sv =====
// Build: taken at the accepting edge; busy stays low.
// Shuffle step: busy after accept while the remainder unit takes one bit per cycle of the
//   RW = min(RAND_WIDTH, 16) low random bits, then for the single-port deck swap.
// Deal of k cards: check state, then one deck read per card; cards strobe one per cycle.
// Refused deal: one strobe from the check state. Results cannot be stalled by the receiver.
// Reset (rst_n low, async): sorted deck, dealt count 0, shuffle position 51, no strobe.
module shuffled_deck_dealer #(
    parameter int RAND_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  req_type,
    input  logic [15:0] rand_value,
    input  logic [5:0]  deal_count,
    output logic [1:0]  suit,
    output logic [3:0]  rank,
    output logic        last,
    output logic        refused,
    output logic        strobe
);

    import sdd_pkg::*;

    // only the low bits of the 16-bit random word take part in the modulo
    localparam int RW = (RAND_WIDTH < 16) ? RAND_WIDTH : 16;

    cmd_t  cmd;
    stat_t stat;

    // Controller sequences each word: divide, then read pos / read j /
    // write pos / write j for a swap, or one deck read per dealt card.
    sdd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .stat     (stat),
        .cmd      (cmd),
        .busy     (busy)
    );

    // Datapath holds the deck RAM (with per-entry valid bits so that a build
    // is a single clear of the valid bits), the remainder unit, counters and result regs.
    sdd_datapath #(
        .RW (RW)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .rand_value (rand_value),
        .deal_count (deal_count),
        .cmd        (cmd),
        .stat       (stat),
        .suit       (suit),
        .rank       (rank),
        .last       (last),
        .refused    (refused),
        .strobe     (strobe)
    );

endmodule

// ===== hdl/sdd_checker.sv =====
module sdd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  req_type,
    input logic [1:0]  suit,
    input logic [3:0]  rank,
    input logic        last,
    input logic        refused,
    input logic        strobe
);

    import sdd_pkg::*;

    // refusal word carries no card and closes the run
    a_refuse_form: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && refused |-> last && suit == 2'd0 && rank == 4'd0)
        else $error("refused word malformed");

    a_rank_range: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !refused |-> rank >= 4'd1 && rank <= 4'd13)
        else $error("card rank out of range");

    a_shuffle_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && req_type == REQ_SHUFFLE |=> busy)
        else $error("shuffle step did not go busy");

    // the final card of a preceding deal may still strobe here
    a_build_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && req_type == REQ_BUILD |=> !busy)
        else $error("build must finish at once");

endmodule

bind shuffled_deck_dealer sdd_checker u_chk (.*);
